### src/fcr_pkg.sv
// Shared types and constants for the feedback comb reverb.
package fcr_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DELAY_W  = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 1'd1;

  localparam logic [DELAY_W-1:0]         DELAY_RESET = 13'd4410;
  localparam logic signed [SAMPLE_W-1:0] DECAY_RESET = 16'sd16384;

  typedef struct packed {
    logic                        channel;
    logic signed [SAMPLE_W-1:0]  sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        out_channel;
  } out_t;

  // How the feedback tap of one transaction is sourced.
  typedef struct packed {
    logic use_mem;    // delay is nonzero, tap comes from the delay store
    logic tap_valid;  // tap entry has been written since reset
  } tap_t;

endpackage

### src/fcr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fcr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/fcr_pos.sv
// Per-channel ring positions and delay store address generation.
module fcr_pos #(
  parameter int unsigned CHANNELS  = 2,
  parameter int unsigned MAX_DELAY = 8192,
  localparam int unsigned AW     = $clog2(MAX_DELAY),
  localparam int unsigned ADDR_W = $clog2(CHANNELS * MAX_DELAY)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        channel_i,
  input  logic [fcr_pkg::DELAY_W-1:0] delay_i,
  output logic [ADDR_W-1:0]           rd_addr_o,
  output logic [ADDR_W-1:0]           wr_addr_o,
  output fcr_pkg::tap_t               tap_o
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned EW = ((AW > fcr_pkg::DELAY_W) ? AW : fcr_pkg::DELAY_W) + 1;
  localparam logic [EW-1:0] MAX_E = EW'(MAX_DELAY);

  logic [AW-1:0] wp_q [CHANNELS];
  logic [AW-1:0] wp_d;
  logic [CHANNELS-1:0] wrapped_q;
  logic [CW-1:0] ch_idx;
  logic [EW-1:0] d_ext, d_eff, wp_ext, rp_ext, wp_inc;
  logic [AW-1:0] wp_cur;

  assign ch_idx = (CHANNELS > 1) ? CW'(channel_i) : '0;
  assign wp_cur = wp_q[ch_idx];
  assign wp_ext = EW'(wp_cur);
  assign d_ext  = EW'(delay_i);
  assign d_eff  = (d_ext >= MAX_E) ? (MAX_E - EW'(1)) : d_ext;
  assign rp_ext = (wp_ext >= d_eff) ? (wp_ext - d_eff) : (wp_ext + MAX_E - d_eff);
  assign wp_inc = wp_ext + EW'(1);
  assign wp_d   = (wp_inc >= MAX_E) ? '0 : wp_inc[AW-1:0];

  // Entries are written in ring order from zero, so before the first wrap an
  // entry holds data only if it lies behind the write position.
  assign tap_o.use_mem   = (d_eff != '0);
  assign tap_o.tap_valid = wrapped_q[ch_idx] || (wp_ext >= d_eff);

  assign rd_addr_o = ADDR_W'(ch_idx) * ADDR_W'(MAX_DELAY) + ADDR_W'(rp_ext[AW-1:0]);
  assign wr_addr_o = ADDR_W'(ch_idx) * ADDR_W'(MAX_DELAY) + ADDR_W'(wp_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        wp_q[i] <= '0;
      end
      wrapped_q <= '0;
    end else if (accept_i) begin
      wp_q[ch_idx] <= wp_d;
      if (wp_inc >= MAX_E) begin
        wrapped_q[ch_idx] <= 1'b1;
      end
    end
  end

endmodule

### src/fcr_mac.sv
// Feedback multiply-accumulate with round-half-up and 16-bit saturation.
module fcr_mac (
  input  logic signed [fcr_pkg::SAMPLE_W-1:0] x_i,
  input  logic signed [fcr_pkg::SAMPLE_W-1:0] fb_i,
  input  logic signed [fcr_pkg::SAMPLE_W-1:0] decay_i,
  output logic signed [fcr_pkg::SAMPLE_W-1:0] y_o
);

  logic signed [31:0] prod;
  logic signed [33:0] acc;
  logic signed [18:0] q;

  assign prod = decay_i * fb_i;
  assign acc  = {{3{x_i[15]}}, x_i, 15'd0} + 34'(prod) + 34'sd16384;
  assign q    = 19'(acc >>> 15);

  always_comb begin
    if (q > 19'sd32767) begin
      y_o = 16'sd32767;
    end else if (q < -19'sd32768) begin
      y_o = -16'sd32768;
    end else begin
      y_o = q[15:0];
    end
  end

endmodule

### src/feedback_comb_reverb.sv
// A result passes through the stage-one register and then the output register after its input is accepted.
// Throughput: one transaction per cycle while the output is not stalled; the delay store is read in the accept
// cycle and written when the result moves to the output register.
// Reset: control and config registers take their defaults at once; there is no clearing pass, since
// per-channel wrap flags make never-written delay entries read as zero.
module feedback_comb_reverb #(
  parameter int unsigned CHANNELS  = 2,
  parameter int unsigned MAX_DELAY = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fcr_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fcr_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fcr_pkg::SAMPLE_W-1:0]  cfg_data_i
);

  localparam int unsigned ADDR_W = $clog2(CHANNELS * MAX_DELAY);

  logic [fcr_pkg::DELAY_W-1:0]         delay_q;
  logic signed [fcr_pkg::SAMPLE_W-1:0] decay_q;

  logic in_acc, s1_adv;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  fcr_pkg::tap_t tap;

  logic                                s1_valid_q;
  logic                                s1_ch_q;
  logic signed [fcr_pkg::SAMPLE_W-1:0] s1_x_q;
  logic [ADDR_W-1:0]                   s1_waddr_q;
  fcr_pkg::tap_t                       s1_tap_q;
  logic                                s1_fwd_q;
  logic signed [fcr_pkg::SAMPLE_W-1:0] s1_fwd_y_q;

  logic signed [fcr_pkg::SAMPLE_W-1:0] rdata, fb, y;
  logic                                out_valid_q;
  fcr_pkg::out_t                       out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= fcr_pkg::DELAY_RESET;
      decay_q <= fcr_pkg::DECAY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fcr_pkg::REG_DELAY_SAMPLES: delay_q <= cfg_data_i[fcr_pkg::DELAY_W-1:0];
        fcr_pkg::REG_DECAY:         decay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  fcr_pos #(
    .CHANNELS (CHANNELS),
    .MAX_DELAY(MAX_DELAY)
  ) u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .channel_i(in_data_i.channel),
    .delay_i  (delay_q),
    .rd_addr_o(rd_addr),
    .wr_addr_o(wr_addr),
    .tap_o    (tap)
  );

  fcr_ram #(
    .WIDTH(fcr_pkg::SAMPLE_W),
    .DEPTH(CHANNELS * MAX_DELAY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q && s1_adv),
    .waddr_i(s1_waddr_q),
    .wdata_i(y),
    .re_i   (in_acc),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // The RAM returns old data when a read hits the entry being written in the
  // same cycle, so the new result is forwarded around it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q    <= in_data_i.channel;
      s1_x_q     <= in_data_i.sample_in;
      s1_waddr_q <= wr_addr;
      s1_tap_q   <= tap;
      s1_fwd_q   <= s1_valid_q && (s1_waddr_q == rd_addr);
      s1_fwd_y_q <= y;
    end
  end

  always_comb begin
    if (!s1_tap_q.use_mem) begin
      fb = s1_x_q;
    end else if (s1_fwd_q) begin
      fb = s1_fwd_y_q;
    end else if (s1_tap_q.tap_valid) begin
      fb = rdata;
    end else begin
      fb = '0;
    end
  end

  fcr_mac u_mac (
    .x_i    (s1_x_q),
    .fb_i   (fb),
    .decay_i(decay_q),
    .y_o    (y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q.sample_out  <= y;
      out_q.out_channel <= s1_ch_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/fcr_checker.sv
// Port-level checker for the feedback comb reverb and its bind statement.
module fcr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input fcr_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input fcr_pkg::out_t out_data_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // With an empty output register the pipeline always drains, so input is open.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output register is empty");

  // A result from an idle output comes from an input accepted into stage one.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output transaction without matching input transaction");

  a_channel_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_data_o.out_channel == $past(in_data_i.channel, 2))
    else $error("output channel does not match input channel");

endmodule

bind feedback_comb_reverb fcr_checker u_fcr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
